// ----- rtl/nnis_pkg.sv -----
// shared types, constants and helpers of the nearest-neighbor image scaler
package nnis_pkg;

  // frame limits
  localparam int MAX_SRC_DIM = 512;
  localparam int MAX_DST_DIM = 1024;

  // fixed field widths
  localparam int SRC_REG_W = 10;
  localparam int DST_REG_W = 11;
  localparam int PIX_W     = 8;

  // derived widths
  localparam int SRC_AW    = $clog2(MAX_SRC_DIM);
  localparam int SRC_DW    = SRC_AW + 1;
  localparam int DST_AW    = $clog2(MAX_DST_DIM);
  localparam int DST_DW    = DST_AW + 1;
  localparam int MEM_AW    = 2 * SRC_AW;
  localparam int MEM_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int PROD_W    = DST_AW + SRC_DW;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [SRC_REG_W-1:0] SRC_WIDTH_RST  = SRC_REG_W'(512);
  localparam logic [SRC_REG_W-1:0] SRC_HEIGHT_RST = SRC_REG_W'(512);
  localparam logic [DST_REG_W-1:0] DST_WIDTH_RST  = DST_REG_W'(256);
  localparam logic [DST_REG_W-1:0] DST_HEIGHT_RST = DST_REG_W'(256);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] src_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             end_of_line;
    logic             end_of_frame;
  } out_item_t;

  // effective (saturated) dimensions
  typedef struct packed {
    logic [SRC_DW-1:0] sw;
    logic [SRC_DW-1:0] sh;
    logic [DST_DW-1:0] dw;
    logic [DST_DW-1:0] dh;
  } dims_t;

  // coordinate unit status toward the top level
  typedef struct packed {
    logic              busy;
    logic [SRC_AW-1:0] sx;
    logic [SRC_AW-1:0] sy;
    logic              eol;
    logic              eof;
  } coord_t;

  function automatic logic [SRC_DW-1:0] clamp_src(input logic [SRC_REG_W-1:0] v);
    if (v == '0) begin
      return SRC_DW'(1);
    end else if (int'(v) > MAX_SRC_DIM) begin
      return SRC_DW'(MAX_SRC_DIM);
    end else begin
      return SRC_DW'(v);
    end
  endfunction

  function automatic logic [DST_DW-1:0] clamp_dst(input logic [DST_REG_W-1:0] v);
    if (v == '0) begin
      return DST_DW'(1);
    end else if (int'(v) > MAX_DST_DIM) begin
      return DST_DW'(MAX_DST_DIM);
    end else begin
      return DST_DW'(v);
    end
  endfunction

endpackage

// ----- rtl/nnis_frame_mem.sv -----
// source frame store: one write port, one registered read port
module nnis_frame_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [nnis_pkg::MEM_AW-1:0]  wr_addr,
  input  logic [nnis_pkg::PIX_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [nnis_pkg::MEM_AW-1:0]  rd_addr,
  output logic [nnis_pkg::PIX_W-1:0]   rd_data
);

  logic [nnis_pkg::PIX_W-1:0] mem [nnis_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/nnis_divider.sv -----
// restoring divider, one quotient bit per cycle
module nnis_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nnis_pkg::PROD_W-1:0]  dividend,
  input  logic [nnis_pkg::DST_DW-1:0]  divisor,
  output logic                         done,
  output logic [nnis_pkg::PROD_W-1:0]  quotient,
  output logic [nnis_pkg::DST_DW-1:0]  remainder
);

  logic                            run_r, run_nxt;
  logic                            done_r, done_nxt;
  logic [nnis_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [nnis_pkg::PROD_W-1:0]     quo_r, quo_nxt;
  logic [nnis_pkg::DST_DW-1:0]     rem_r, rem_nxt;
  logic [nnis_pkg::DST_DW-1:0]     dvs_r, dvs_nxt;
  logic [nnis_pkg::DST_DW:0]       rem_sh;
  logic                            ge;

  assign rem_sh = {rem_r, quo_r[nnis_pkg::PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = nnis_pkg::DIV_CNT_W'(nnis_pkg::PROD_W - 1);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      quo_nxt = {quo_r[nnis_pkg::PROD_W-2:0], ge};
      rem_nxt = ge ? nnis_pkg::DST_DW'(rem_sh - {1'b0, dvs_r})
                   : rem_sh[nnis_pkg::DST_DW-1:0];
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/nnis_coord.sv -----
// destination position counters, incremental source mapping and its rebuild sequencer
module nnis_coord (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                restart,
  input  nnis_pkg::dims_t     dims,
  output nnis_pkg::coord_t    status
);

  typedef enum logic [1:0] {ST_READY, ST_MUL, ST_START, ST_WAIT} state_t;
  typedef enum logic [1:0] {JOB_STEP_X, JOB_STEP_Y, JOB_POS_X, JOB_POS_Y} job_t;

  localparam int SAW = nnis_pkg::SRC_AW;
  localparam int SDW = nnis_pkg::SRC_DW;
  localparam int DAW = nnis_pkg::DST_AW;
  localparam int DDW = nnis_pkg::DST_DW;
  localparam int PW  = nnis_pkg::PROD_W;

  state_t          state_r, state_nxt;
  job_t            job_r, job_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [DDW-1:0]  divisor_r, divisor_nxt;
  // integer step per destination pixel, kept modulo the coordinate range
  logic [SAW-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [DAW-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SAW-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [DAW-1:0]  remx_r, remx_nxt, remy_r, remy_nxt;
  logic [DAW-1:0]  col_r, col_nxt, row_r, row_nxt;

  logic            div_done;
  logic [PW-1:0]   div_quo;
  logic [DDW-1:0]  div_rem;

  logic [DDW-1:0]  col_inc, row_inc;
  logic            eol, last_row;
  logic [DAW-1:0]  colc, rowc;
  logic [DDW-1:0]  tx, ty;
  logic            wrap_x, wrap_y;
  logic [DAW-1:0]  mul_a;
  logic [SDW-1:0]  mul_b;
  logic [DDW-1:0]  mul_d;

  nnis_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_START),
    .dividend  (prod_r),
    .divisor   (divisor_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign eol      = col_inc >= dims.dw;
  assign last_row = row_inc >= dims.dh;

  // counters left beyond a shrunk frame map as the last line or column
  assign colc = ({1'b0, col_r} < dims.dw) ? col_r : DAW'(dims.dw - 1'b1);
  assign rowc = ({1'b0, row_r} < dims.dh) ? row_r : DAW'(dims.dh - 1'b1);

  assign tx     = DDW'(remx_r) + DDW'(rx_r);
  assign ty     = DDW'(remy_r) + DDW'(ry_r);
  assign wrap_x = tx >= dims.dw;
  assign wrap_y = ty >= dims.dh;

  always_comb begin
    unique case (job_r)
      JOB_STEP_X: begin mul_a = DAW'(1); mul_b = dims.sw; mul_d = dims.dw; end
      JOB_STEP_Y: begin mul_a = DAW'(1); mul_b = dims.sh; mul_d = dims.dh; end
      JOB_POS_X:  begin mul_a = colc;    mul_b = dims.sw; mul_d = dims.dw; end
      JOB_POS_Y:  begin mul_a = rowc;    mul_b = dims.sh; mul_d = dims.dh; end
      default:    begin mul_a = '0;      mul_b = '0;      mul_d = '0;      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    prod_nxt    = prod_r;
    divisor_nxt = divisor_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    remx_nxt    = remx_r;
    remy_nxt    = remy_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    priority if (restart) begin
      state_nxt = ST_MUL;
      job_nxt   = JOB_STEP_X;
    end else begin
      unique case (state_r)
        ST_READY: begin
          if (step) begin
            if (eol) begin
              col_nxt  = '0;
              sx_nxt   = '0;
              remx_nxt = '0;
              if (last_row) begin
                row_nxt  = '0;
                sy_nxt   = '0;
                remy_nxt = '0;
              end else begin
                row_nxt  = DAW'(row_inc);
                sy_nxt   = sy_r + qy_r + SAW'(wrap_y);
                remy_nxt = wrap_y ? DAW'(ty - dims.dh) : DAW'(ty);
              end
            end else begin
              col_nxt  = DAW'(col_inc);
              sx_nxt   = sx_r + qx_r + SAW'(wrap_x);
              remx_nxt = wrap_x ? DAW'(tx - dims.dw) : DAW'(tx);
            end
          end
        end
        ST_MUL: begin
          prod_nxt    = PW'(mul_a) * PW'(mul_b);
          divisor_nxt = mul_d;
          state_nxt   = ST_START;
        end
        ST_START: begin
          state_nxt = ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            state_nxt = ST_MUL;
            unique case (job_r)
              JOB_STEP_X: begin
                qx_nxt  = div_quo[SAW-1:0];
                rx_nxt  = div_rem[DAW-1:0];
                job_nxt = JOB_STEP_Y;
              end
              JOB_STEP_Y: begin
                qy_nxt  = div_quo[SAW-1:0];
                ry_nxt  = div_rem[DAW-1:0];
                job_nxt = JOB_POS_X;
              end
              JOB_POS_X: begin
                sx_nxt   = div_quo[SAW-1:0];
                remx_nxt = div_rem[DAW-1:0];
                job_nxt  = JOB_POS_Y;
              end
              JOB_POS_Y: begin
                sy_nxt    = div_quo[SAW-1:0];
                remy_nxt  = div_rem[DAW-1:0];
                job_nxt   = JOB_STEP_X;
                state_nxt = ST_READY;
              end
              default: begin
                job_nxt = JOB_STEP_X;
              end
            endcase
          end
        end
        default: begin
          state_nxt = ST_MUL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    divisor_r <= divisor_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    remx_r    <= remx_nxt;
    remy_r    <= remy_nxt;
    if (!rst_n) begin
      state_r <= ST_MUL;
      job_r   <= JOB_STEP_X;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  assign status.busy = state_r != ST_READY;
  assign status.sx   = sx_r;
  assign status.sy   = sy_r;
  assign status.eol  = eol;
  assign status.eof  = eol && last_row;

endmodule

// ----- rtl/nearest_neighbor_image_scaler.sv -----
// top level of the nearest-neighbor grayscale image scaler
//
// usage
// - input channel: an item transfers at a rising edge with start high and busy low.
//   op load writes in_item.src_pixel to the frame store at the next raster position;
//   op emit requests the next destination pixel in raster order
// - result channel: one result per emit item, on out_item for exactly one cycle with
//   out_valid high, in the cycle after the item transfers; the receiver cannot stall it
// - throughput: one item per cycle while busy is low; the frame store takes one write
//   and one registered read per cycle and the source coordinates step incrementally
// - configuration: APB-style, registers at byte addresses 0, 4, 8, 12 (source width,
//   source height, destination width, destination height), pready always high
// - after reset and after every register write, busy stays high while the
//   coordinate unit rebuilds its step sizes and current source position with a
//   shared serial divider (four divisions, one after another)
// - reset clears the position counters and restores the register defaults; the frame
//   store is not cleared, so a full source frame must be loaded before emitting
module nearest_neighbor_image_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  nnis_pkg::in_item_t                in_item,
  // result channel
  output logic                              out_valid,
  output nnis_pkg::out_item_t               out_item,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [nnis_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [nnis_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [nnis_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SAW = nnis_pkg::SRC_AW;
  localparam int SDW = nnis_pkg::SRC_DW;

  // configuration registers, as written
  logic [nnis_pkg::SRC_REG_W-1:0] src_width_r, src_height_r;
  logic [nnis_pkg::DST_REG_W-1:0] dst_width_r, dst_height_r;

  logic                cfg_wr;
  nnis_pkg::reg_idx_t  cfg_idx;
  nnis_pkg::dims_t     dims;
  nnis_pkg::coord_t    coord;

  logic                accept, accept_load, accept_emit;

  // source load position
  logic [SAW-1:0]      load_col_r, load_row_r;
  logic [SDW-1:0]      load_col_inc, load_row_inc;
  logic [SAW-1:0]      wr_col, wr_row;

  // result strobe and marks
  logic                out_valid_r;
  logic                eol_r, eof_r;
  logic [nnis_pkg::PIX_W-1:0] rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = nnis_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnis_pkg::SRC_WIDTH_RST;
      src_height_r <= nnis_pkg::SRC_HEIGHT_RST;
      dst_width_r  <= nnis_pkg::DST_WIDTH_RST;
      dst_height_r <= nnis_pkg::DST_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nnis_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_pwdata[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_pwdata[nnis_pkg::SRC_REG_W-1:0];
        nnis_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_pwdata[nnis_pkg::DST_REG_W-1:0];
        nnis_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_pwdata[nnis_pkg::DST_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      nnis_pkg::REG_SRC_WIDTH:  cfg_prdata = nnis_pkg::CFG_DW'(src_width_r);
      nnis_pkg::REG_SRC_HEIGHT: cfg_prdata = nnis_pkg::CFG_DW'(src_height_r);
      nnis_pkg::REG_DST_WIDTH:  cfg_prdata = nnis_pkg::CFG_DW'(dst_width_r);
      nnis_pkg::REG_DST_HEIGHT: cfg_prdata = nnis_pkg::CFG_DW'(dst_height_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // zero and oversized dimensions saturate into the legal range
  assign dims.sw = nnis_pkg::clamp_src(src_width_r);
  assign dims.sh = nnis_pkg::clamp_src(src_height_r);
  assign dims.dw = nnis_pkg::clamp_dst(dst_width_r);
  assign dims.dh = nnis_pkg::clamp_dst(dst_height_r);

  // input transfer
  assign busy        = coord.busy;
  assign accept      = start && !busy;
  assign accept_load = accept && (in_item.op == nnis_pkg::OP_LOAD);
  assign accept_emit = accept && (in_item.op == nnis_pkg::OP_EMIT);

  // coordinate unit: destination counters and the source pixel they map to
  nnis_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept_emit),
    .restart (cfg_wr),
    .dims    (dims),
    .status  (coord)
  );

  // load position; a position left beyond a shrunk source frame writes the last
  // line or column and wraps on its next advance
  assign load_col_inc = {1'b0, load_col_r} + 1'b1;
  assign load_row_inc = {1'b0, load_row_r} + 1'b1;
  assign wr_col = ({1'b0, load_col_r} < dims.sw) ? load_col_r : SAW'(dims.sw - 1'b1);
  assign wr_row = ({1'b0, load_row_r} < dims.sh) ? load_row_r : SAW'(dims.sh - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r <= '0;
      load_row_r <= '0;
    end else if (accept_load) begin
      if (load_col_inc >= dims.sw) begin
        load_col_r <= '0;
        load_row_r <= (load_row_inc >= dims.sh) ? '0 : SAW'(load_row_inc);
      end else begin
        load_col_r <= SAW'(load_col_inc);
      end
    end
  end

  // frame store, row-major at the maximum source pitch; a read in the cycle after a
  // write to the same entry already sees the new pixel
  nnis_frame_mem u_mem (
    .clk     (clk),
    .wr_en   (accept_load),
    .wr_addr ({wr_row, wr_col}),
    .wr_data (in_item.src_pixel),
    .rd_en   (accept_emit),
    .rd_addr ({coord.sy, coord.sx}),
    .rd_data (rd_data)
  );

  // result strobe lines up with the registered read data
  always_ff @(posedge clk) begin
    if (accept_emit) begin
      eol_r <= coord.eol;
      eof_r <= coord.eof;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept_emit;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_item.out_pixel    = rd_data;
  assign out_item.end_of_line  = eol_r;
  assign out_item.end_of_frame = eof_r;

  // every result comes from an emit item transferred in the previous cycle
  a_result_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept_emit))
    else $error("result without an emit transfer");

  // a register write always triggers a rebuild of the coordinate unit
  a_cfg_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("register write did not start a rebuild");

  // the frame mark only comes on the last pixel of a line
  a_eof_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_frame |-> out_item.end_of_line)
    else $error("end of frame without end of line");

  // once rebuilt, the source coordinate stays inside the source frame
  a_src_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ({1'b0, coord.sx} < dims.sw) && ({1'b0, coord.sy} < dims.sh))
    else $error("source coordinate outside the source frame");

endmodule
